@@ src/mvc_pkg.sv @@
// Shared types, widths and arithmetic helpers for the mesh vertex curvature block.
`default_nettype none
package mvc_pkg;

    localparam int CW       = 32;
    localparam int FB       = 16;
    localparam int ANG_IN_W = 19;
    localparam int LAP_W    = 64;
    localparam int AREA_W   = 48;
    localparam int ANGLE_W  = 40;
    localparam int NORM_W   = 48;
    localparam int UNIT_W   = 18;
    localparam int PROD_W   = 2 * CW + 1;
    localparam int SQ_W     = 2 * NORM_W;
    localparam int SUMSQ_W  = SQ_W + 2;
    localparam int ROOT_W   = NORM_W + 1;
    localparam int NUM_W    = LAP_W + FB;
    localparam int DEN_W    = AREA_W + 2;
    localparam int QUO_W    = CW + 2;
    localparam int GNUM_W   = ANGLE_W + 2;
    localparam int CNT_W    = 7;

    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 184;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int FCNT_W     = 3;

    localparam logic [63:0] TWO_PI_Q32 = 64'h6487ED511;
    localparam logic [63:0] TWO_PI_FULL = (TWO_PI_Q32 + (64'd1 << (31 - FB))) >> (32 - FB);
    localparam logic [GNUM_W-1:0] TWO_PI_Q = TWO_PI_FULL[GNUM_W-1:0];

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_EDGE  = 2'd1,
        OP_FACE  = 2'd2,
        OP_END   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic [CW-1:0]            scalar_a;
        logic [ANG_IN_W-1:0]      corner_angle;
        logic [2:0][CW-1:0]       vec;
    } item_t;

    typedef struct packed {
        logic                     start;
        logic [NUM_W-1:0]         num;
        logic [DEN_W-1:0]         den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic [QUO_W-1:0]         quot;
        logic                     big;
    } div_rsp_t;

    typedef struct packed {
        logic [2:0][UNIT_W-1:0]   unit_normal;
        logic [CW-1:0]            gauss_curvature;
        logic [2:0][CW-1:0]       mean_normal;
        logic                     saturated_flag;
        logic                     zero_normal_flag;
        logic                     zero_area_flag;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_MUL,
        ST_EDGE_ACC,
        ST_SQ,
        ST_ROOT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } back_state_t;

    function automatic logic [LAP_W-1:0] sadd_lap(logic [LAP_W-1:0] a, logic [LAP_W-1:0] b);
        logic [LAP_W:0] s;
        s = {a[LAP_W-1], a} + {b[LAP_W-1], b};
        if (s[LAP_W] != s[LAP_W-1])
            return s[LAP_W] ? {1'b1, {(LAP_W-1){1'b0}}} : {1'b0, {(LAP_W-1){1'b1}}};
        return s[LAP_W-1:0];
    endfunction

    function automatic logic [AREA_W-1:0] sadd_48(logic [AREA_W-1:0] a, logic [CW-1:0] b);
        logic [AREA_W:0] s;
        s = {a[AREA_W-1], a} + {{(AREA_W+1-CW){b[CW-1]}}, b};
        if (s[AREA_W] != s[AREA_W-1])
            return s[AREA_W] ? {1'b1, {(AREA_W-1){1'b0}}} : {1'b0, {(AREA_W-1){1'b1}}};
        return s[AREA_W-1:0];
    endfunction

    function automatic logic [LAP_W-1:0] mag_lap(logic [LAP_W-1:0] x);
        return x[LAP_W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [AREA_W-1:0] mag_48(logic [AREA_W-1:0] x);
        return x[AREA_W-1] ? (~x + 1'b1) : x;
    endfunction

endpackage
`default_nettype wire

@@ src/mvc_front.sv @@
// Input side: accepts stream transactions, decodes them and queues them for the back end.
`default_nettype none
module mvc_front
    import mvc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    input  wire logic [1:0]           s_tuser,
    output logic                      item_valid,
    output item_t                     item,
    input  wire logic                 pop
);

    item_t             fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0] count_reg, count_next;
    item_t             item_in;
    logic              push;

    always_comb
    begin
        item_in.op           = op_t'(s_tuser);
        item_in.scalar_a     = s_tdata[31:0];
        item_in.corner_angle = s_tdata[50:32];
        item_in.vec[0]       = s_tdata[82:51];
        item_in.vec[1]       = s_tdata[114:83];
        item_in.vec[2]       = s_tdata[146:115];
    end

    assign s_tready   = (count_reg != FCNT_W'(FIFO_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign item_valid = (count_reg != '0);
    assign item       = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + FCNT_W'(push) - FCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= item_in;
    end

endmodule
`default_nettype wire

@@ src/mvc_div.sv @@
// Restoring divider, one quotient bit per cycle, with an overflow mark for large quotients.
`default_nettype none
module mvc_div
    import mvc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [QUO_W-1:0] quot_reg, quot_next;
    logic             big_reg, big_next;
    logic [DEN_W:0]   trial;
    logic             take;

    always_comb
    begin
        trial = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
        take  = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        big_next  = big_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            num_next  = req.num;
            den_next  = req.den;
            quot_next = '0;
            big_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next  = take ? trial - {1'b0, den_reg} : trial;
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            quot_next = {quot_reg[QUO_W-2:0], take};
            // A bit pushed out of the top means the quotient is far beyond any limit.
            big_next  = big_reg | quot_reg[QUO_W-1];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        big_reg  <= big_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.big  = big_reg;

endmodule
`default_nettype wire

@@ src/mvc_back.sv @@
// Execution side: accumulators, squaring, square root, division sequencing and result register.
`default_nettype none
module mvc_back
    import mvc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    input  wire item_t    item,
    output logic          pop,
    output div_req_t      div_req,
    input  wire div_rsp_t div_rsp,
    output logic          out_valid,
    input  wire logic     out_ready,
    output result_t       out_data
);

    localparam logic [2:0] JOB_GAUSS = 3'd3;
    localparam logic [2:0] JOB_UNIT0 = 3'd4;
    localparam logic [2:0] JOB_LAST  = 3'd6;

    back_state_t state_reg, state_next;

    item_t                   cur_reg;
    logic [1:0]              axis_reg;
    logic [CW-1:0]           centre_reg [3];
    logic [LAP_W-1:0]        lap_reg [3];
    logic [AREA_W-1:0]       area_reg;
    logic [ANGLE_W-1:0]      angle_reg;
    logic [NORM_W-1:0]       norm_reg [3];
    logic signed [PROD_W-1:0] prod_reg;
    logic [SQ_W-1:0]         mcand_reg;
    logic [NORM_W-1:0]       mplier_reg;
    logic [SUMSQ_W-1:0]      sumsq_reg;
    logic [SUMSQ_W-1:0]      rop_reg, rres_reg, rone_reg;
    logic [ROOT_W-1:0]       len_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [2:0]              job_reg;
    result_t                 res_reg;
    logic                    out_valid_reg;
    result_t                 out_reg;

    logic                    start_item;
    logic                    skip_job;
    logic                    job_neg;
    logic [LAP_W-1:0]        job_nmag;
    logic [DEN_W-1:0]        job_den;
    logic [GNUM_W-1:0]       gnum;
    logic [GNUM_W-1:0]       gmag;
    logic [QUO_W-1:0]        limit;
    logic                    over;
    logic [QUO_W-1:0]        qclip;
    logic [QUO_W-1:0]        qunit;
    logic                    out_free;
    logic                    sq_last, root_last, job_last;
    logic [SUMSQ_W-1:0]      sq_sum;
    logic [SUMSQ_W-1:0]      rt_try;
    logic [SUMSQ_W-1:0]      rres_new;
    logic signed [CW:0]      diff;
    logic signed [PROD_W-1:0] prod_mul;
    logic [NORM_W-1:0]       next_mag;

    assign out_free  = !out_valid_reg || out_ready;
    assign sq_last   = (cnt_reg == CNT_W'(NORM_W - 1));
    assign root_last = (cnt_reg == CNT_W'(ROOT_W - 1));
    assign job_last  = (job_reg == JOB_LAST);

    // Job operands: mean normal components, then Gaussian curvature, then unit normal.
    always_comb
    begin
        gnum     = TWO_PI_Q - {{(GNUM_W-ANGLE_W){1'b0}}, angle_reg};
        gmag     = gnum[GNUM_W-1] ? (~gnum + 1'b1) : gnum;
        job_neg  = 1'b0;
        job_nmag = '0;
        job_den  = {1'b0, mag_48(area_reg), 1'b0};
        skip_job = res_reg.zero_area_flag;
        case (job_reg)
            3'd0, 3'd1, 3'd2:
            begin
                job_neg  = lap_reg[job_reg[1:0]][LAP_W-1] ^ area_reg[AREA_W-1];
                job_nmag = mag_lap(lap_reg[job_reg[1:0]]);
            end
            JOB_GAUSS:
            begin
                job_neg  = gnum[GNUM_W-1] ^ area_reg[AREA_W-1];
                job_nmag = {{(LAP_W-GNUM_W){1'b0}}, gmag};
                job_den  = {2'b0, mag_48(area_reg)};
            end
            default:
            begin
                job_neg  = norm_reg[2'(job_reg - JOB_UNIT0)][NORM_W-1];
                job_nmag = {{(LAP_W-NORM_W){1'b0}}, mag_48(norm_reg[2'(job_reg - JOB_UNIT0)])};
                job_den  = {1'b0, len_reg};
                skip_job = res_reg.zero_normal_flag;
            end
        endcase
        limit = job_neg ? (QUO_W'(1) << (CW - 1)) : ((QUO_W'(1) << (CW - 1)) - 1'b1);
        over  = div_rsp.big || (div_rsp.quot > limit);
        qclip = over ? limit : div_rsp.quot;
        qunit = (div_rsp.big || (div_rsp.quot > (QUO_W'(1) << FB))) ? (QUO_W'(1) << FB)
                                                                    : div_rsp.quot;
    end

    always_comb
    begin
        sq_sum   = mplier_reg[0] ? sumsq_reg + {2'b0, mcand_reg} : sumsq_reg;
        rt_try   = rres_reg + rone_reg;
        rres_new = (rop_reg >= rt_try) ? (rres_reg >> 1) + rone_reg : (rres_reg >> 1);
        diff     = $signed({cur_reg.vec[axis_reg][CW-1], cur_reg.vec[axis_reg]})
                 - $signed({centre_reg[axis_reg][CW-1], centre_reg[axis_reg]});
        prod_mul = $signed(cur_reg.scalar_a) * diff;
        next_mag = (axis_reg == 2'd2) ? '0 : mag_48(norm_reg[2'(axis_reg + 1'b1)]);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (item_valid)
                begin
                    unique case (item.op)
                        OP_EDGE: state_next = ST_EDGE_MUL;
                        OP_END:  state_next = ST_SQ;
                        default: state_next = ST_IDLE;
                    endcase
                end
            ST_EDGE_MUL:
                state_next = ST_EDGE_ACC;
            ST_EDGE_ACC:
                state_next = (axis_reg == 2'd2) ? ST_IDLE : ST_EDGE_MUL;
            ST_SQ:
                if (sq_last && axis_reg == 2'd2)
                    state_next = ST_ROOT;
            ST_ROOT:
                if (root_last)
                    state_next = ST_DIV_START;
            ST_DIV_START:
                if (!skip_job)
                    state_next = ST_DIV_WAIT;
                else if (job_last)
                    state_next = ST_OUT;
            ST_DIV_WAIT:
                if (div_rsp.done)
                    state_next = job_last ? ST_OUT : ST_DIV_START;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        pop           = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = {job_nmag, {FB{1'b0}}};
        div_req.den   = job_den;
        unique case (state_reg)
            ST_IDLE:      pop = item_valid;
            ST_DIV_START: div_req.start = !skip_job;
            default:      pop = 1'b0;
        endcase
    end

    assign start_item  = pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                centre_reg[i] <= '0;
                lap_reg[i]    <= '0;
                norm_reg[i]   <= '0;
            end
            area_reg  <= '0;
            angle_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (start_item && item.op == OP_BEGIN)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    centre_reg[i] <= item.vec[i];
                    lap_reg[i]    <= '0;
                    norm_reg[i]   <= '0;
                end
                area_reg  <= '0;
                angle_reg <= '0;
            end
            else if (start_item && item.op == OP_FACE)
            begin
                logic [ANGLE_W:0] asum;
                asum = {1'b0, angle_reg} + {{(ANGLE_W+1-ANG_IN_W){1'b0}}, item.corner_angle};
                area_reg  <= sadd_48(area_reg, item.scalar_a);
                angle_reg <= asum[ANGLE_W] ? {ANGLE_W{1'b1}} : asum[ANGLE_W-1:0];
                for (int i = 0; i < 3; i++)
                    norm_reg[i] <= sadd_48(norm_reg[i], item.vec[i]);
            end
            else if (state_reg == ST_EDGE_ACC)
            begin
                // Product back to FB fraction bits, rounding toward minus infinity.
                lap_reg[axis_reg] <= sadd_lap(lap_reg[axis_reg],
                    {{(LAP_W-(PROD_W-FB)){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:FB]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_item)
        begin
            cur_reg  <= item;
            axis_reg <= 2'd0;
            if (item.op == OP_END)
            begin
                cnt_reg                  <= '0;
                sumsq_reg                <= '0;
                mcand_reg                <= {{(SQ_W-NORM_W){1'b0}}, mag_48(norm_reg[0])};
                mplier_reg               <= mag_48(norm_reg[0]);
                res_reg                  <= '0;
                res_reg.zero_area_flag   <= (area_reg == '0);
            end
        end
        unique case (state_reg)
            ST_EDGE_MUL:
                prod_reg <= prod_mul;
            ST_EDGE_ACC:
                axis_reg <= axis_reg + 1'b1;
            ST_SQ:
            begin
                sumsq_reg  <= sq_sum;
                mcand_reg  <= {mcand_reg[SQ_W-2:0], 1'b0};
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg + 1'b1;
                if (sq_last)
                begin
                    cnt_reg    <= '0;
                    axis_reg   <= axis_reg + 1'b1;
                    mcand_reg  <= {{(SQ_W-NORM_W){1'b0}}, next_mag};
                    mplier_reg <= next_mag;
                    if (axis_reg == 2'd2)
                    begin
                        rop_reg                  <= sq_sum;
                        rres_reg                 <= '0;
                        rone_reg                 <= SUMSQ_W'(1) << (2 * (ROOT_W - 1));
                        res_reg.zero_normal_flag <= (sq_sum == '0);
                    end
                end
            end
            ST_ROOT:
            begin
                if (rop_reg >= rt_try)
                    rop_reg <= rop_reg - rt_try;
                rres_reg <= rres_new;
                rone_reg <= rone_reg >> 2;
                cnt_reg  <= cnt_reg + 1'b1;
                if (root_last)
                begin
                    len_reg <= rres_new[ROOT_W-1:0];
                    job_reg <= '0;
                end
            end
            ST_DIV_START:
                if (skip_job)
                    job_reg <= job_reg + 1'b1;
            ST_DIV_WAIT:
                if (div_rsp.done)
                begin
                    job_reg <= job_reg + 1'b1;
                    case (job_reg)
                        3'd0, 3'd1, 3'd2:
                        begin
                            res_reg.mean_normal[job_reg[1:0]] <=
                                job_neg ? CW'(~qclip + 1'b1) : CW'(qclip);
                            res_reg.saturated_flag <= res_reg.saturated_flag | over;
                        end
                        JOB_GAUSS:
                        begin
                            res_reg.gauss_curvature <= job_neg ? CW'(~qclip + 1'b1) : CW'(qclip);
                            res_reg.saturated_flag  <= res_reg.saturated_flag | over;
                        end
                        default:
                            res_reg.unit_normal[2'(job_reg - JOB_UNIT0)] <=
                                job_neg ? UNIT_W'(~qunit + 1'b1) : UNIT_W'(qunit);
                    endcase
                end
            ST_OUT:
                if (out_free)
                    out_reg <= res_reg;
            default:
                ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

@@ src/mesh_vertex_curvature.sv @@
// Top level of the mesh vertex curvature block.
// Computes discrete mean curvature normal, Gaussian curvature and unit vertex normal per vertex
// from a run of transactions (begin, edge terms, face corner terms, end) in signed Q16.16.
// A four-entry queue decouples the input from the execution unit. Edge items run one 32x33
// multiply per axis. An end item runs the bit-serial sums of squares of the normal, then the
// digit-by-digit square root, then up to seven divisions in the shared one-bit-per-cycle
// divider; divisions for a zero area or zero normal are skipped. The result waits in an
// output register while the next items are accepted.
`default_nettype none
module mesh_vertex_curvature
    import mvc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // scalar_a[31:0], corner_angle[50:32], vec_x[82:51], vec_y[114:83], vec_z[146:115], zero pad
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // op[1:0]
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // mean_normal_x[31:0], mean_normal_y[63:32], mean_normal_z[95:64], gauss_curvature[127:96],
    // unit_normal_x[145:128], unit_normal_y[163:146], unit_normal_z[181:164], zero pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // zero_area_flag[0], zero_normal_flag[1], saturated_flag[2]
    output logic [2:0]                 m_tuser
);

    logic     item_valid;
    item_t    item;
    logic     pop;
    div_req_t div_req;
    div_rsp_t div_rsp;
    result_t  res;

    mvc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop)
    );

    mvc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mvc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (res)
    );

    assign m_tdata = {2'b00, res.unit_normal, res.gauss_curvature, res.mean_normal};
    assign m_tuser = {res.saturated_flag, res.zero_normal_flag, res.zero_area_flag};

endmodule
`default_nettype wire

@@ src/mvc_checker.sv @@
// Port-level checks for the mesh vertex curvature block, bound to its top level.
`default_nettype none
module mvc_checker
    import mvc_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [IN_DATA_W-1:0]  s_tdata,
    input wire logic [1:0]            s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic [2:0]            m_tuser
);

    // A stalled result transaction must stay offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A zero area forces both curvatures to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[127:0] == '0) && !m_tuser[2])
        else $error("zero area with nonzero curvature");

    // A zero normal sum forces the unit normal to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata[181:128] == '0))
        else $error("zero normal with nonzero unit normal");

endmodule

bind mesh_vertex_curvature mvc_checker u_mvc_checker (.*);
`default_nettype wire
